// ===== rtl/sfd_pkg.sv =====
`default_nettype none
package sfd_pkg;
	localparam logic [29:0] WordSat = 30'h3FFF_FFFF;
	localparam logic [11:0] FmtMask = 12'hFFF;
	localparam logic [31:0] RawHdrFixed = 32'd12;

	typedef enum logic [1:0] {
		KIND_DESC = 2'd0,
		KIND_HDR  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_VERSION = 2'd1,
		ERR_ADDR    = 2'd2,
		ERR_TRUNC   = 2'd3
	} err_t;

	// one entry of the queue between classifier and emitter
	typedef struct packed {
		kind_t       kind;
		logic [31:0] header_word;
		logic [2:0]  word_bytes;
		logic        last_header_word;
		logic [31:0] samp_rate;
		logic [31:0] frame_len;
		logic [31:0] snap_length;
		logic [31:0] source_id;
		logic [31:0] input_port;
		logic [31:0] output_port;
		err_t        error_code;
	} ent_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] header_word;
		logic [2:0]  word_bytes;
		logic        last_header_word;
		logic [31:0] samp_rate;
		logic [31:0] frame_len;
		logic [31:0] snap_length;
		logic [63:0] sampled_bytes;
		logic [31:0] source_id;
		logic [31:0] input_port;
		logic [31:0] output_port;
		logic [1:0]  error_code;
	} res_t;

	function automatic logic [29:0] words_of(input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, b} + 33'd3;
		return (s[32]) ? WordSat : s[31:2];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/sfd_if.sv =====
`default_nettype none
interface sfd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        last_word;
	modport source (output valid, data_word, last_word, input ready);
	modport sink (input valid, data_word, last_word, output ready);
endinterface

interface sfd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] header_word;
	logic [2:0]  word_bytes;
	logic        last_header_word;
	logic [31:0] samp_rate;
	logic [31:0] frame_len;
	logic [31:0] snap_length;
	logic [63:0] sampled_bytes;
	logic [31:0] source_id;
	logic [31:0] input_port;
	logic [31:0] output_port;
	logic [1:0]  error_code;
	modport source (output valid, kind, header_word, word_bytes, last_header_word,
		samp_rate, frame_len, snap_length, sampled_bytes, source_id,
		input_port, output_port, error_code, input ready);
	modport sink (input valid, kind, header_word, word_bytes, last_header_word,
		samp_rate, frame_len, snap_length, sampled_bytes, source_id,
		input_port, output_port, error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfd_front.sv =====
`default_nettype none
module sfd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire logic [31:0]        w,
	input  wire logic               last,
	input  wire logic [3:0]         fcs_length,
	output sfd_pkg::ent_t           ent,
	output logic                    ent_valid
);
	import sfd_pkg::*;

	typedef enum logic [25:0] {
		PH_VERSION    = 26'd1 << 0,
		PH_ADDRTYPE   = 26'd1 << 1,
		PH_HSKIP      = 26'd1 << 2,
		PH_NSAMPLES   = 26'd1 << 3,
		PH_SFORMAT    = 26'd1 << 4,
		PH_SLEN_FLOW  = 26'd1 << 5,
		PH_SLEN_OTHER = 26'd1 << 6,
		PH_SSKIP      = 26'd1 << 7,
		PH_FS_SEQ     = 26'd1 << 8,
		PH_FS_SRC     = 26'd1 << 9,
		PH_FS_RATE    = 26'd1 << 10,
		PH_FS_TOTAL   = 26'd1 << 11,
		PH_FS_DROPS   = 26'd1 << 12,
		PH_FS_IN      = 26'd1 << 13,
		PH_FS_OUT     = 26'd1 << 14,
		PH_FS_NREC    = 26'd1 << 15,
		PH_RTYPE      = 26'd1 << 16,
		PH_RLEN_RAW   = 26'd1 << 17,
		PH_RLEN_OTHER = 26'd1 << 18,
		PH_RSKIP      = 26'd1 << 19,
		PH_RH_PROTO   = 26'd1 << 20,
		PH_RH_FLEN    = 26'd1 << 21,
		PH_RH_STRIP   = 26'd1 << 22,
		PH_RH_SNAP    = 26'd1 << 23,
		PH_RH_HDR     = 26'd1 << 24,
		PH_DONE       = 26'd1 << 25
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [31:0] drec_q, drec_d, srec_q, srec_d, hbytes_q, hbytes_d;
	logic [29:0] skip_q, skip_d, rwords_q, rwords_d;
	logic [31:0] rate_q, flen_q, src_q, inp_q, outp_q;
	logic        proto_eth_q, drop_q, drop_d;
	logic        samp_end, rec_end, hdr, emit;
	err_t        err;
	logic [29:0] wo, rw_dec;
	logic [31:0] srec_dec, drec_dec;
	logic [2:0]  wb;
	logic [31:0] wb32, hb_new;
	logic        fin;
	ent_t        e;

	always_comb begin
		ph_d = ph_q; drec_d = drec_q; srec_d = srec_q; hbytes_d = hbytes_q;
		skip_d = skip_q; rwords_d = rwords_q; drop_d = drop_q;
		samp_end = 1'b0; rec_end = 1'b0; hdr = 1'b0; emit = 1'b0; err = ERR_NONE;
		e = '0;
		wo = words_of(w);
		rw_dec = rwords_q - 30'd1;
		srec_dec = srec_q - 32'd1;
		drec_dec = drec_q - 32'd1;
		wb = (hbytes_q < 32'd4) ? hbytes_q[2:0] : 3'd4;
		wb32 = {29'd0, wb};
		hb_new = hbytes_q - wb32;
		fin = (hb_new == 32'd0) || (rw_dec == 30'd0);
		unique case (ph_q)
			PH_VERSION: begin
				if (w != 32'd5) err = ERR_VERSION;
				else ph_d = PH_ADDRTYPE;
			end
			PH_ADDRTYPE: begin
				if (w == 32'd1) begin skip_d = 30'd4; ph_d = PH_HSKIP; end
				else if (w == 32'd2) begin skip_d = 30'd7; ph_d = PH_HSKIP; end
				else err = ERR_ADDR;
			end
			PH_HSKIP: begin
				skip_d = skip_q - 30'd1;
				if (skip_d == 30'd0) ph_d = PH_NSAMPLES;
			end
			PH_NSAMPLES: begin
				drec_d = w;
				ph_d = (w == 32'd0) ? PH_DONE : PH_SFORMAT;
			end
			PH_SFORMAT: ph_d = ((w[11:0] & FmtMask) == 12'd1) ? PH_SLEN_FLOW : PH_SLEN_OTHER;
			PH_SLEN_FLOW: ph_d = PH_FS_SEQ;
			PH_SLEN_OTHER: begin
				skip_d = wo;
				if (wo == 30'd0) samp_end = 1'b1;
				else ph_d = PH_SSKIP;
			end
			PH_SSKIP: begin
				skip_d = skip_q - 30'd1;
				if (skip_d == 30'd0) samp_end = 1'b1;
			end
			PH_FS_SEQ: ph_d = PH_FS_SRC;
			PH_FS_SRC: ph_d = PH_FS_RATE;
			PH_FS_RATE: ph_d = PH_FS_TOTAL;
			PH_FS_TOTAL: ph_d = PH_FS_DROPS;
			PH_FS_DROPS: ph_d = PH_FS_IN;
			PH_FS_IN: ph_d = PH_FS_OUT;
			PH_FS_OUT: ph_d = PH_FS_NREC;
			PH_FS_NREC: begin
				srec_d = w;
				if (w == 32'd0) samp_end = 1'b1;
				else ph_d = PH_RTYPE;
			end
			PH_RTYPE: ph_d = (w == 32'd1) ? PH_RLEN_RAW : PH_RLEN_OTHER;
			PH_RLEN_RAW: begin
				rwords_d = words_of((w >= RawHdrFixed) ? w - RawHdrFixed : 32'd0);
				ph_d = PH_RH_PROTO;
			end
			PH_RLEN_OTHER: begin
				rwords_d = wo;
				if (wo == 30'd0) rec_end = 1'b1;
				else ph_d = PH_RSKIP;
			end
			PH_RSKIP: begin
				rwords_d = rw_dec;
				if (rw_dec == 30'd0) rec_end = 1'b1;
			end
			PH_RH_PROTO: ph_d = PH_RH_FLEN;
			PH_RH_FLEN: ph_d = PH_RH_STRIP;
			PH_RH_STRIP: begin
				if (rwords_q == 30'd0) rec_end = 1'b1;
				else ph_d = proto_eth_q ? PH_RH_SNAP : PH_RSKIP;
			end
			PH_RH_SNAP: begin
				rwords_d = rw_dec;
				hbytes_d = w;
				emit = 1'b1;
				e.kind = KIND_DESC;
				e.samp_rate = rate_q;
				e.frame_len = flen_q;
				e.snap_length = w;
				e.source_id = src_q;
				e.input_port = inp_q;
				e.output_port = outp_q;
				if (rw_dec == 30'd0) rec_end = 1'b1;
				else ph_d = (w == 32'd0) ? PH_RSKIP : PH_RH_HDR;
			end
			PH_RH_HDR: begin
				rwords_d = rw_dec;
				hbytes_d = hb_new;
				emit = 1'b1; hdr = 1'b1;
				e.kind = KIND_HDR;
				e.header_word = w;
				e.word_bytes = wb;
				e.last_header_word = fin;
				if (fin) begin
					if (rw_dec == 30'd0) rec_end = 1'b1;
					else ph_d = PH_RSKIP;
				end
			end
			PH_DONE: ;
			default: ph_d = PH_DONE;
		endcase
		if (rec_end) begin
			srec_d = srec_dec;
			if (srec_dec == 32'd0) samp_end = 1'b1;
			else ph_d = PH_RTYPE;
		end
		if (samp_end) begin
			drec_d = drec_dec;
			ph_d = (drec_dec == 32'd0) ? PH_DONE : PH_SFORMAT;
		end
		if (err != ERR_NONE) begin
			e = '0; e.kind = KIND_ERR; e.error_code = err; emit = 1'b1;
			drop_d = !last; ph_d = PH_VERSION;
		end else if (last) begin
			if (ph_d != PH_DONE) begin
				if (hdr) begin
					e.last_header_word = 1'b1; e.error_code = ERR_TRUNC;
				end else begin
					e = '0; e.kind = KIND_ERR; e.error_code = ERR_TRUNC;
				end
				emit = 1'b1;
			end
			ph_d = PH_VERSION;
		end
		if (drop_q) begin
			emit = 1'b0; ph_d = ph_q; drec_d = drec_q; srec_d = srec_q;
			hbytes_d = hbytes_q; skip_d = skip_q; rwords_d = rwords_q;
			drop_d = 1'b1;
			if (last) begin drop_d = 1'b0; ph_d = PH_VERSION; end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_VERSION; drop_q <= 1'b0;
			drec_q <= '0; srec_q <= '0; hbytes_q <= '0; skip_q <= '0; rwords_q <= '0;
			rate_q <= '0; flen_q <= '0; src_q <= '0; inp_q <= '0; outp_q <= '0;
			proto_eth_q <= 1'b0; ent_valid <= 1'b0;
		end else begin
			ent_valid <= acc && emit;
			if (acc) begin
				ph_q <= ph_d; drop_q <= drop_d; drec_q <= drec_d; srec_q <= srec_d;
				hbytes_q <= hbytes_d; skip_q <= skip_d; rwords_q <= rwords_d;
				if (!drop_q) begin
					if (ph_q == PH_FS_SRC) src_q <= w;
					if (ph_q == PH_FS_RATE) rate_q <= w;
					if (ph_q == PH_FS_IN) inp_q <= w;
					if (ph_q == PH_FS_OUT) outp_q <= w;
					if (ph_q == PH_RH_PROTO) proto_eth_q <= (w == 32'd1);
					if (ph_q == PH_RH_FLEN)
						flen_q <= (w >= {28'd0, fcs_length}) ? w - {28'd0, fcs_length} : 32'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) ent <= e;
	end
endmodule
`default_nettype wire

// ===== rtl/sfd_back.sv =====
`default_nettype none
module sfd_back #(
	parameter int unsigned Depth = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire sfd_pkg::ent_t in_ent,
	output logic               space_ok,
	sfd_out_if.source          o
);
	import sfd_pkg::*;

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	ent_t          mem [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;
	logic          pop, s1_load, s1_v_q, s2_v_q, s2_take;
	ent_t          e_s1;
	res_t          r_s2;

	// stages s1 and s2 follow the queue, the multiply sits between s1 and s2
	assign s2_take = !s2_v_q || o.ready;
	assign s1_load = !s1_v_q || s2_take;
	assign pop = (cnt_q != '0) && s1_load;
	// front has one word in flight ahead of the queue
	assign space_ok = (cnt_q + {{Aw{1'b0}}, in_valid}) < (Aw+1)'(Depth - 1);

	always_ff @(posedge clk) begin
		if (in_valid) mem[wp_q] <= in_ent;
		if (pop) e_s1 <= mem[rp_q];
		if (s1_v_q && s2_take) begin
			r_s2.kind <= e_s1.kind;
			r_s2.header_word <= e_s1.header_word;
			r_s2.word_bytes <= e_s1.word_bytes;
			r_s2.last_header_word <= e_s1.last_header_word;
			r_s2.samp_rate <= e_s1.samp_rate;
			r_s2.frame_len <= e_s1.frame_len;
			r_s2.snap_length <= e_s1.snap_length;
			r_s2.sampled_bytes <= 64'(e_s1.frame_len) * 64'(e_s1.samp_rate);
			r_s2.source_id <= e_s1.source_id;
			r_s2.input_port <= e_s1.input_port;
			r_s2.output_port <= e_s1.output_port;
			r_s2.error_code <= e_s1.error_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; s1_v_q <= 1'b0; s2_v_q <= 1'b0;
		end else begin
			if (in_valid) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + {{Aw{1'b0}}, in_valid} - {{Aw{1'b0}}, pop};
			if (s1_load) s1_v_q <= pop;
			if (s2_take) s2_v_q <= s1_v_q;
		end
	end

	assign o.valid = s2_v_q;
	assign o.kind = r_s2.kind;
	assign o.header_word = r_s2.header_word;
	assign o.word_bytes = r_s2.word_bytes;
	assign o.last_header_word = r_s2.last_header_word;
	assign o.samp_rate = r_s2.samp_rate;
	assign o.frame_len = r_s2.frame_len;
	assign o.snap_length = r_s2.snap_length;
	assign o.sampled_bytes = r_s2.sampled_bytes;
	assign o.source_id = r_s2.source_id;
	assign o.input_port = r_s2.input_port;
	assign o.output_port = r_s2.output_port;
	assign o.error_code = r_s2.error_code;
endmodule
`default_nettype wire

// ===== rtl/sflow_v5_datagram_deframer.sv =====
// result path: a taken word passes the front entry register, the queue, s1 and the multiply stage s2
// throughput: one datagram word per cycle while the result queue has room
// input stalls once the queue, counting the word being written, holds Depth-1 words
// the product is one 32x32 multiply in the last stage
// reset: arst_n asynchronous active low, parser waits for a version word, fcs_length 4
`default_nettype none
module sflow_v5_datagram_deframer #(
	parameter int unsigned Depth = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfd_in_if.sink           din,
	sfd_out_if.source        dout,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfd_pkg::*;

	localparam logic [1:0] AddrFcs = 2'd0;

	logic [3:0] fcs_q;
	logic       acc, ent_valid, space_ok;
	ent_t       ent;

	// config register, byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr == AddrFcs) ? {28'd0, fcs_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fcs_q <= 4'd4;
		else if (psel && penable && pwrite && paddr == AddrFcs) fcs_q <= pwdata[3:0];
	end

	// input word taken whenever the queue can absorb what is in flight
	assign din.ready = space_ok;
	assign acc = din.valid && din.ready;

	sfd_front u_front (
		.clk, .arst_n, .acc, .w(din.data_word), .last(din.last_word),
		.fcs_length(fcs_q), .ent, .ent_valid
	);

	sfd_back #(.Depth(Depth)) u_back (
		.clk, .arst_n, .in_valid(ent_valid), .in_ent(ent), .space_ok, .o(dout)
	);

`ifndef ASSERT_OFF
	// an error word never carries header flags
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.kind == KIND_ERR |-> dout.last_header_word == 1'b0)
		else $error("error word with header flag");
	// the descriptor product follows its operands
	a_prod: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.kind == KIND_DESC |->
		dout.sampled_bytes == 64'(dout.frame_len) * 64'(dout.samp_rate))
		else $error("sampled_bytes mismatch");
`endif
endmodule
`default_nettype wire
